// ===== rtl/cas_pkg.sv =====
// shared constants, types and structs for the cave smoothing block
// used by cas_line_cell, cas_rule and cave_automaton_smoother_top; no dependencies
package cas_pkg;

    // grid limits
    localparam int CAS_MAX_W  = 256;
    localparam int CAS_MAX_H  = 256;
    localparam int CAS_COL_W  = $clog2(CAS_MAX_W);
    localparam int CAS_ROW_W  = $clog2(CAS_MAX_H);
    localparam int CAS_WDIM_W = CAS_COL_W + 1;
    localparam int CAS_HDIM_W = CAS_ROW_W + 1;
    localparam int CAS_LEAD_W = CAS_COL_W + 2;

    // register field widths
    localparam int CAS_CFG_DIM_W = 9;
    localparam int CAS_POINT_W   = 8;
    localparam int CAS_RAD_W     = 17;
    localparam int CAS_OUT_W     = 8;

    // 5x5 window, line store keeps the four rows above the current one
    localparam int CAS_WIN    = 5;
    localparam int CAS_LINE_B = CAS_WIN - 1;

    // smoothing rule thresholds and register reset values
    localparam int CAS_C3_KEEP   = 4;
    localparam int CAS_C5_SPARSE = 3;
    localparam int CAS_RAD_RST   = 49;
    localparam int CAS_DIM_RST   = 64;

    typedef logic [CAS_LINE_B-1:0] t_line;
    typedef logic [CAS_WIN-1:0]    t_col;
    typedef logic [CAS_WIN-1:0][CAS_WIN-1:0] t_win;

    typedef struct packed {
        logic [CAS_WDIM_W-1:0]  w;
        logic [CAS_HDIM_W-1:0]  h;
        logic                   closing;
        logic [CAS_POINT_W-1:0] sx;
        logic [CAS_POINT_W-1:0] sy;
        logic [CAS_POINT_W-1:0] fx;
        logic [CAS_POINT_W-1:0] fy;
        logic [CAS_RAD_W-1:0]   radius;
    } t_cfg;

    typedef struct packed {
        t_win                 win;
        logic [CAS_COL_W-1:0] ex;
        logic [CAS_ROW_W-1:0] ey;
        logic                 last;
    } t_emit;

endpackage

// ===== rtl/cave_automaton_smoother_top.sv =====
// top level of the cave smoothing block: register port, raster control, line store chain
// depends on cas_pkg, cas_line_cell and cas_rule
//
// Cave smoothing over a raster stream of wall/floor cells. One cell transfer
// is taken per clock while s_axis_tready is high; the smoothed cell (x, y) is
// produced when cell (x+2, y+2) is taken, and flush transfers drain the last
// 2*W+2 cells once the frame is in, one per flush. Cells outside the grid count
// as walls. The line store is a chain of MAX_WIDTH cells, each holding four row
// bits of one column; the chain length follows grid_width, so no clearing pass
// is needed after reset or a geometry change. Sustained rate is one transfer per
// clock in both directions while m_axis_tready stays high; a result reaches the
// master side through the window snapshot, count and square, and decision
// register stages. When a frame holds fewer than 2*W+3 cells, the block shifts
// the chain on its own after the last cell, with tready low, until the window
// lead is complete, before it takes the first flush. Registers are to be
// written only while idle, which the block does not enforce; a write of
// grid_width or grid_height restarts the frame.
module cave_automaton_smoother_top
    import cas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cell_wall, [7:1] zero
    input  logic [0:0]  s_axis_tuser,   // [0] action: 1 flush
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] new_wall, [8:1] out_col, [16:9] out_row, [23:17] zero
    output logic        m_axis_tlast,   // frame_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CLOSING     = 3'd2;
    localparam logic [2:0] REG_START_X     = 3'd3;
    localparam logic [2:0] REG_START_Y     = 3'd4;
    localparam logic [2:0] REG_FINISH_X    = 3'd5;
    localparam logic [2:0] REG_FINISH_Y    = 3'd6;
    localparam logic [2:0] REG_RADIUS      = 3'd7;

    // pushes ahead of the emitted cell: two rows and two columns plus the cell itself
    localparam int LEAD_EXTRA = 3;
    localparam int TDATA_USED = 1 + 2 * CAS_OUT_W;

    // configuration registers
    logic [CAS_CFG_DIM_W-1:0] r_grid_width;
    logic [CAS_CFG_DIM_W-1:0] r_grid_height;
    logic                     r_closing_mode;
    logic [CAS_POINT_W-1:0]   r_start_x;
    logic [CAS_POINT_W-1:0]   r_start_y;
    logic [CAS_POINT_W-1:0]   r_finish_x;
    logic [CAS_POINT_W-1:0]   r_finish_y;
    logic [CAS_RAD_W-1:0]     r_clear_radius_sq;

    // raster control
    logic [CAS_COL_W-1:0]  r_in_col;
    logic [CAS_HDIM_W-1:0] r_in_row;
    logic [CAS_COL_W-1:0]  r_ex;
    logic [CAS_ROW_W-1:0]  r_ey;
    logic [CAS_LEAD_W-1:0] r_lead;

    // 5x5 window, slot 0 is the newest column
    t_win r_win;
    t_win n_win;

    logic [CAS_WDIM_W-1:0] w_eff;
    logic [CAS_HDIM_W-1:0] h_eff;
    logic [CAS_COL_W-1:0]  w_m1;
    logic [CAS_LEAD_W-1:0] lead_max;

    logic cfg_wr;
    logic geom_wr;
    logic acc;
    logic is_flush;
    logic frame_in;
    logic catchup;
    logic push_cell;
    logic push_flush;
    logic push;
    logic emit;
    logic emit_last;
    logic in_col_wrap;
    logic ex_wrap;
    logic lead_near;
    logic rule_ready;
    logic new_bit;

    t_line line_q [CAS_MAX_W];
    t_line entry;
    t_col  col_vec;
    t_cfg  cfg;
    t_emit emit_d;

    logic                 res_wall;
    logic [CAS_COL_W-1:0] res_col;
    logic [CAS_ROW_W-1:0] res_row;

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign geom_wr = cfg_wr && ((paddr[4:2] == REG_GRID_WIDTH) || (paddr[4:2] == REG_GRID_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width      <= CAS_CFG_DIM_W'(CAS_DIM_RST);
            r_grid_height     <= CAS_CFG_DIM_W'(CAS_DIM_RST);
            r_closing_mode    <= 1'b1;
            r_start_x         <= '0;
            r_start_y         <= '0;
            r_finish_x        <= '0;
            r_finish_y        <= '0;
            r_clear_radius_sq <= CAS_RAD_W'(CAS_RAD_RST);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_GRID_WIDTH:  r_grid_width      <= pwdata[CAS_CFG_DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height     <= pwdata[CAS_CFG_DIM_W-1:0];
                REG_CLOSING:     r_closing_mode    <= pwdata[0];
                REG_START_X:     r_start_x         <= pwdata[CAS_POINT_W-1:0];
                REG_START_Y:     r_start_y         <= pwdata[CAS_POINT_W-1:0];
                REG_FINISH_X:    r_finish_x        <= pwdata[CAS_POINT_W-1:0];
                REG_FINISH_Y:    r_finish_y        <= pwdata[CAS_POINT_W-1:0];
                REG_RADIUS:      r_clear_radius_sq <= pwdata[CAS_RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_GRID_WIDTH:  prdata = 32'(r_grid_width);
            REG_GRID_HEIGHT: prdata = 32'(r_grid_height);
            REG_CLOSING:     prdata = 32'(r_closing_mode);
            REG_START_X:     prdata = 32'(r_start_x);
            REG_START_Y:     prdata = 32'(r_start_y);
            REG_FINISH_X:    prdata = 32'(r_finish_x);
            REG_FINISH_Y:    prdata = 32'(r_finish_y);
            REG_RADIUS:      prdata = 32'(r_clear_radius_sq);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // effective geometry, clamped to 1..max
    // ---------------------------------------------------------------
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = CAS_WDIM_W'(1);
        end else if (32'(r_grid_width) > CAS_MAX_W) begin
            w_eff = CAS_WDIM_W'(CAS_MAX_W);
        end else begin
            w_eff = CAS_WDIM_W'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            h_eff = CAS_HDIM_W'(1);
        end else if (32'(r_grid_height) > CAS_MAX_H) begin
            h_eff = CAS_HDIM_W'(CAS_MAX_H);
        end else begin
            h_eff = CAS_HDIM_W'(r_grid_height);
        end
    end

    assign w_m1     = CAS_COL_W'(w_eff - CAS_WDIM_W'(1));
    assign lead_max = (CAS_LEAD_W'(w_eff) << 1) + CAS_LEAD_W'(LEAD_EXTRA);

    // ---------------------------------------------------------------
    // transfer control
    // ---------------------------------------------------------------
    assign frame_in  = (r_in_row == h_eff);
    // the flush that emits cell 0 must itself be the push that completes the lead
    assign lead_near = (r_lead >= lead_max - CAS_LEAD_W'(1));
    assign catchup   = frame_in && !lead_near;

    assign s_axis_tready = rule_ready && !catchup;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign is_flush      = s_axis_tuser[0];

    assign push_cell  = acc && !is_flush && !frame_in;
    assign push_flush = acc && is_flush && frame_in;
    // catch-up pushes dummy columns below the grid, masked as walls later
    assign push       = push_cell || push_flush || catchup;
    assign emit       = (push_cell && lead_near) || push_flush;

    assign in_col_wrap = (CAS_WDIM_W'(r_in_col) + CAS_WDIM_W'(1)) == w_eff;
    assign ex_wrap     = r_ex == w_m1;
    assign emit_last   = ex_wrap && (CAS_HDIM_W'(r_ey) == h_eff - CAS_HDIM_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_lead   <= '0;
        end else if (geom_wr) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_lead   <= '0;
        end else if (emit && emit_last) begin
            // frame done, the next cell starts a new frame at (0, 0)
            r_in_col <= '0;
            r_in_row <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_lead   <= '0;
        end else begin
            if (push_cell) begin
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + CAS_HDIM_W'(1);
                end else begin
                    r_in_col <= r_in_col + CAS_COL_W'(1);
                end
            end
            // lead saturates once the window is far enough ahead
            if (push && (r_lead != lead_max)) begin
                r_lead <= r_lead + CAS_LEAD_W'(1);
            end
            if (emit) begin
                if (ex_wrap) begin
                    r_ex <= '0;
                    r_ey <= r_ey + CAS_ROW_W'(1);
                end else begin
                    r_ex <= r_ex + CAS_COL_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // line store chain: entry at cell W-1, output at cell 0, so a column
    // word comes back after exactly W pushes
    // ---------------------------------------------------------------
    assign new_bit = push_cell ? s_axis_tdata[0] : 1'b0;
    assign col_vec = {line_q[0], new_bit};          // bit j is row (push row - j)
    assign entry   = col_vec[CAS_LINE_B-1:0];

    for (genvar k = 0; k < CAS_MAX_W; k++) begin : g_line
        t_line nxt;
        if (k == CAS_MAX_W - 1) begin : g_end
            assign nxt = entry;
        end else begin : g_mid
            assign nxt = line_q[k+1];
        end
        cas_line_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (push),
            .i_entry_sel (w_m1 == CAS_COL_W'(k)),
            .i_entry     (entry),
            .i_next      (nxt),
            .o_data      (line_q[k])
        );
    end

    // window shift
    always_comb begin
        n_win[0] = col_vec;
        for (int k = 1; k < CAS_WIN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_win <= n_win;
        end
    end

    // ---------------------------------------------------------------
    // rule pipeline and result stream
    // ---------------------------------------------------------------
    assign cfg.w       = w_eff;
    assign cfg.h       = h_eff;
    assign cfg.closing = r_closing_mode;
    assign cfg.sx      = r_start_x;
    assign cfg.sy      = r_start_y;
    assign cfg.fx      = r_finish_x;
    assign cfg.fy      = r_finish_y;
    assign cfg.radius  = r_clear_radius_sq;

    assign emit_d.win  = n_win;
    assign emit_d.ex   = r_ex;
    assign emit_d.ey   = r_ey;
    assign emit_d.last = emit_last;

    cas_rule u_rule (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (emit),
        .i_emit  (emit_d),
        .o_ready (rule_ready),
        .o_vld   (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_wall  (res_wall),
        .o_col   (res_col),
        .o_row   (res_row),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(24 - TDATA_USED)'(0), res_row[CAS_OUT_W-1:0],
                           res_col[CAS_OUT_W-1:0], res_wall};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a flush only emits once the window lead is complete
    a_flush_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_flush |-> lead_near)
        else $error("flush emitted before the window lead was complete");

    // pushes that carry no cell happen only after the whole frame is in
    a_drain_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !push_cell) |-> frame_in)
        else $error("dummy or flush push before the frame was complete");

    // the final cell restarts the frame
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_in_row == '0 && r_in_col == '0 && r_ex == '0
                                 && r_ey == '0 && r_lead == '0))
        else $error("frame counters not cleared after the final cell");

endmodule

// ===== rtl/cas_line_cell.sv =====
// one cell of the variable-length line store chain
// depends on cas_pkg
module cas_line_cell
    import cas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  logic  i_entry_sel,
    input  t_line i_entry,
    input  t_line i_next,
    output t_line o_data
);

    t_line r_data;

    // the entry cell takes the new column word, all others take their neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_entry_sel ? i_entry : i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/cas_rule.sv =====
// neighbor counting, distance check and smoothing decision, three register stages
// depends on cas_pkg
module cas_rule
    import cas_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_vld,
    input  t_emit                i_emit,
    output logic                 o_ready,
    output logic                 o_vld,
    input  logic                 i_ready,
    output logic                 o_wall,
    output logic [CAS_COL_W-1:0] o_col,
    output logic [CAS_ROW_W-1:0] o_row,
    output logic                 o_last
);

    localparam int XW = CAS_COL_W + 2;
    localparam int YW = CAS_ROW_W + 2;
    localparam int SQ_XW = 2 * CAS_COL_W;
    localparam int SQ_YW = 2 * CAS_ROW_W;
    localparam int DW = 32;

    // stage 1: window snapshot
    logic  r_s1_vld;
    t_emit r_s1;

    // stage 2: counts and squares
    logic                 r_s2_vld;
    logic [3:0]           r_s2_c3;
    logic [4:0]           r_s2_c5;
    logic                 r_s2_ctr;
    logic [SQ_XW-1:0]     r_s2_sqsx;
    logic [SQ_YW-1:0]     r_s2_sqsy;
    logic [SQ_XW-1:0]     r_s2_sqfx;
    logic [SQ_YW-1:0]     r_s2_sqfy;
    logic [CAS_COL_W-1:0] r_s2_col;
    logic [CAS_ROW_W-1:0] r_s2_row;
    logic                 r_s2_last;

    // output stage
    logic                 r_o_vld;
    logic                 r_o_wall;
    logic [CAS_COL_W-1:0] r_o_col;
    logic [CAS_ROW_W-1:0] r_o_row;
    logic                 r_o_last;

    logic s2_rdy;
    logic out_rdy;

    logic [CAS_WIN-1:0] col_ok;
    logic [CAS_WIN-1:0] row_ok;
    t_win               v;
    logic [3:0]         n_c3;
    logic [4:0]         n_c5;
    logic [CAS_COL_W-1:0] adx_s;
    logic [CAS_COL_W-1:0] adx_f;
    logic [CAS_ROW_W-1:0] ady_s;
    logic [CAS_ROW_W-1:0] ady_f;
    logic [CAS_COL_W-1:0] sx_c;
    logic [CAS_COL_W-1:0] fx_c;
    logic [CAS_ROW_W-1:0] sy_c;
    logic [CAS_ROW_W-1:0] fy_c;

    logic [DW-1:0] dist_s;
    logic [DW-1:0] dist_f;
    logic          close_hit;
    logic          n_wall;

    assign s2_rdy  = !r_s2_vld || out_rdy;
    assign out_rdy = !r_o_vld || i_ready;
    assign o_ready = !r_s1_vld || s2_rdy;

    // grid edge masks: slot k is column ex+2-k, row j is ey+2-j
    always_comb begin
        col_ok[0] = (XW'(r_s1.ex) + XW'(2)) < XW'(i_cfg.w);
        col_ok[1] = (XW'(r_s1.ex) + XW'(1)) < XW'(i_cfg.w);
        col_ok[2] = 1'b1;
        col_ok[3] = r_s1.ex != '0;
        col_ok[4] = r_s1.ex > CAS_COL_W'(1);
        row_ok[0] = (YW'(r_s1.ey) + YW'(2)) < YW'(i_cfg.h);
        row_ok[1] = (YW'(r_s1.ey) + YW'(1)) < YW'(i_cfg.h);
        row_ok[2] = 1'b1;
        row_ok[3] = r_s1.ey != '0;
        row_ok[4] = r_s1.ey > CAS_ROW_W'(1);
        for (int k = 0; k < CAS_WIN; k++) begin
            for (int j = 0; j < CAS_WIN; j++) begin
                v[k][j] = (col_ok[k] && row_ok[j]) ? r_s1.win[k][j] : 1'b1;
            end
        end
    end

    assign n_c3 = 4'($countones({v[1][3:1], v[2][3], v[2][1], v[3][3:1]}));
    assign n_c5 = 5'($countones(v)) - 5'(v[2][2]);

    assign sx_c = CAS_COL_W'(i_cfg.sx);
    assign fx_c = CAS_COL_W'(i_cfg.fx);
    assign sy_c = CAS_ROW_W'(i_cfg.sy);
    assign fy_c = CAS_ROW_W'(i_cfg.fy);

    assign adx_s = (r_s1.ex >= sx_c) ? r_s1.ex - sx_c : sx_c - r_s1.ex;
    assign adx_f = (r_s1.ex >= fx_c) ? r_s1.ex - fx_c : fx_c - r_s1.ex;
    assign ady_s = (r_s1.ey >= sy_c) ? r_s1.ey - sy_c : sy_c - r_s1.ey;
    assign ady_f = (r_s1.ey >= fy_c) ? r_s1.ey - fy_c : fy_c - r_s1.ey;

    // decision from registered counts and squares
    assign dist_s = DW'(r_s2_sqsx) + DW'(r_s2_sqsy);
    assign dist_f = DW'(r_s2_sqfx) + DW'(r_s2_sqfy);

    assign close_hit = i_cfg.closing && (r_s2_c5 < 5'(CAS_C5_SPARSE))
                       && (dist_s > DW'(i_cfg.radius)) && (dist_f > DW'(i_cfg.radius));

    always_comb begin
        if ((r_s2_c3 > 4'(CAS_C3_KEEP)) || close_hit) begin
            n_wall = 1'b1;
        end else if (r_s2_c3 < 4'(CAS_C3_KEEP)) begin
            n_wall = 1'b0;
        end else begin
            n_wall = r_s2_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_vld <= i_vld;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_rdy) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_s1 <= i_emit;
        end
        if (s2_rdy && r_s1_vld) begin
            r_s2_c3   <= n_c3;
            r_s2_c5   <= n_c5;
            r_s2_ctr  <= r_s1.win[2][2];
            r_s2_sqsx <= SQ_XW'(adx_s) * SQ_XW'(adx_s);
            r_s2_sqfx <= SQ_XW'(adx_f) * SQ_XW'(adx_f);
            r_s2_sqsy <= SQ_YW'(ady_s) * SQ_YW'(ady_s);
            r_s2_sqfy <= SQ_YW'(ady_f) * SQ_YW'(ady_f);
            r_s2_col  <= r_s1.ex;
            r_s2_row  <= r_s1.ey;
            r_s2_last <= r_s1.last;
        end
        if (out_rdy && r_s2_vld) begin
            r_o_wall <= n_wall;
            r_o_col  <= r_s2_col;
            r_o_row  <= r_s2_row;
            r_o_last <= r_s2_last;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_wall = r_o_wall;
    assign o_col  = r_o_col;
    assign o_row  = r_o_row;
    assign o_last = r_o_last;

endmodule

// ===== bench/cave_automaton_smoother_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for cave_automaton_smoother_top: apb setup, stream stimulus with idling
// and a cell-accurate model of the 3x3/5x5 smoothing rule; depends on cas_pkg and the rtl
module cave_automaton_smoother_top_tb;
    import cas_pkg::*;

    // quiet cycles before giving up, long output hold for back-pressure
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int STORE_DEPTH    = CAS_WIN;

    typedef enum int {
        REG_GRID_W    = 0,
        REG_GRID_H    = 1,
        REG_CLOSING   = 2,
        REG_START_X   = 3,
        REG_START_Y   = 4,
        REG_FINISH_X  = 5,
        REG_FINISH_Y  = 6,
        REG_CLEAR_RAD = 7
    } t_reg_index;

    typedef enum bit {
        ACT_CELL  = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    typedef struct packed {
        bit       wall;
        bit [7:0] col;
        bit [7:0] row;
        bit       last;
    } t_smoothed_cell;

    // model of the block: five-row cell store, raster counters, register copies,
    // and the queue of smoothed cells still owed by the block
    class t_cave_checker;
        bit             cells [STORE_DEPTH][CAS_MAX_W];
        int unsigned    col_in;
        int unsigned    row_in;
        int unsigned    next_emit;
        bit [8:0]       width_reg;
        bit [8:0]       height_reg;
        bit             closing_reg;
        bit [7:0]       sx_reg;
        bit [7:0]       sy_reg;
        bit [7:0]       fx_reg;
        bit [7:0]       fy_reg;
        bit [16:0]      radius_reg;
        t_smoothed_cell pending_cells[$];
        int unsigned    mismatches = 0;
        int unsigned    checked = 0;

        function void reset_state();
            foreach (cells[r, c]) cells[r][c] = 1'b0;
            col_in      = 0;
            row_in      = 0;
            next_emit   = 0;
            width_reg   = 9'(CAS_DIM_RST);
            height_reg  = 9'(CAS_DIM_RST);
            closing_reg = 1'b1;
            sx_reg      = '0;
            sy_reg      = '0;
            fx_reg      = '0;
            fy_reg      = '0;
            radius_reg  = 17'(CAS_RAD_RST);
            pending_cells.delete();
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > CAS_MAX_W) return CAS_MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > CAS_MAX_H) return CAS_MAX_H;
            return height_reg;
        endfunction

        function void write_reg(t_reg_index idx, bit [31:0] value);
            case (idx)
                REG_GRID_W: begin
                    width_reg = value[8:0];
                    col_in = 0; row_in = 0; next_emit = 0;
                end
                REG_GRID_H: begin
                    height_reg = value[8:0];
                    col_in = 0; row_in = 0; next_emit = 0;
                end
                REG_CLOSING:   closing_reg = value[0];
                REG_START_X:   sx_reg = value[7:0];
                REG_START_Y:   sy_reg = value[7:0];
                REG_FINISH_X:  fx_reg = value[7:0];
                REG_FINISH_Y:  fy_reg = value[7:0];
                REG_CLEAR_RAD: radius_reg = value[16:0];
                default: ;
            endcase
        endfunction

        // anything off the grid reads as wall
        function bit wall_at(int x, int y, int unsigned w, int unsigned h);
            if (x < 0 || y < 0 || x >= int'(w) || y >= int'(h)) return 1'b1;
            return cells[y % STORE_DEPTH][x];
        endfunction

        function void smooth_next_cell(int unsigned w, int unsigned h);
            int ex, ey, c3, c5, d_start, d_finish;
            bit v;
            t_smoothed_cell res;
            ex = next_emit % w;
            ey = next_emit / w;
            c3 = 0;
            c5 = 0;
            for (int dy = -2; dy <= 2; dy++) begin
                for (int dx = -2; dx <= 2; dx++) begin
                    if (dx == 0 && dy == 0) continue;
                    v = wall_at(ex + dx, ey + dy, w, h);
                    c5 += v;
                    if (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1) c3 += v;
                end
            end
            d_start  = (ex - int'(sx_reg)) * (ex - int'(sx_reg))
                     + (ey - int'(sy_reg)) * (ey - int'(sy_reg));
            d_finish = (ex - int'(fx_reg)) * (ex - int'(fx_reg))
                     + (ey - int'(fy_reg)) * (ey - int'(fy_reg));
            if (c3 > CAS_C3_KEEP || (closing_reg && c5 < CAS_C5_SPARSE &&
                d_start > int'(radius_reg) && d_finish > int'(radius_reg)))
                res.wall = 1'b1;
            else if (c3 < CAS_C3_KEEP)
                res.wall = 1'b0;
            else
                res.wall = cells[ey % STORE_DEPTH][ex];
            res.col  = ex[7:0];
            res.row  = ey[7:0];
            res.last = (next_emit + 1 >= w * h);
            pending_cells = {pending_cells, res};
            if (res.last) begin
                col_in = 0; row_in = 0; next_emit = 0;
            end else begin
                next_emit++;
            end
        endfunction

        // one accepted input transfer; queues the smoothed cell it releases, if any
        function void take_cell_item(t_action act, bit wall);
            int unsigned w, h, total, received;
            w = eff_width();
            h = eff_height();
            total = w * h;
            if (col_in >= w) col_in = 0;
            if (row_in > h) row_in = h;
            if (row_in == h) col_in = 0;
            received = row_in * w + col_in;
            if (act == ACT_FLUSH) begin
                if (received == total && next_emit < total) smooth_next_cell(w, h);
                return;
            end
            // cell while the frame drains is dropped
            if (received == total) return;
            cells[row_in % STORE_DEPTH][col_in] = wall;
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            received++;
            if (next_emit < total && received < total && received >= next_emit + 2 * w + 3)
                smooth_next_cell(w, h);
            else if (next_emit < total && received == total && total >= next_emit + 2 * w + 3)
                smooth_next_cell(w, h);
        endfunction

        // whole frame in, cells still owed to flush transfers
        function bit draining();
            int unsigned w, h, r, c;
            w = eff_width();
            h = eff_height();
            r = (row_in > h) ? h : row_in;
            c = (r == h || col_in >= w) ? 0 : col_in;
            return (r * w + c == w * h) && next_emit < w * h;
        endfunction

        function void check_smoothed(bit [23:0] data, bit last);
            t_smoothed_cell got, want;
            got.wall = data[0];
            got.col  = data[8:1];
            got.row  = data[16:9];
            got.last = last;
            checked++;
            if (pending_cells.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected cell wall %0b col %0d row %0d last %0b",
                             $time, got.wall, got.col, got.row, got.last);
                mismatches++;
                return;
            end
            want = pending_cells.pop_front();
            if (got != want) begin
                if (mismatches < 10)
                    $display({"%0t: cell mismatch, expected wall %0b col %0d row %0d last %0b,",
                              " got wall %0b col %0d row %0d last %0b"}, $time,
                             want.wall, want.col, want.row, want.last,
                             got.wall, got.col, got.row, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] cell_wall, [7:1] zero
    logic [0:0]  s_axis_tuser;   // [0] action: 1 flush
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [0] new_wall, [8:1] out_col, [16:9] out_row, [23:17] zero
    logic        m_axis_tlast;   // frame_last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_cave_checker sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_req;
    int unsigned   items_sent;
    int unsigned   idle_cycles;

    cave_automaton_smoother_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor: register writes, results and input transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                sb.write_reg(t_reg_index'(int'(paddr[4:2])), pwdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_smoothed(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_cell_item(t_action'(s_axis_tuser[0]), s_axis_tdata[0]);
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still owed",
                         $time, WATCHDOG_LIMIT, sb.pending_cells.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold counted here on request
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(input t_reg_index idx, input bit [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(int'(idx) * 4);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input t_reg_index idx, input bit [31:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 5'(int'(idx) * 4);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            if (sb.mismatches < 10)
                $display("%0t: register %0d read %0h, expected %0h",
                         $time, int'(idx), prdata, want);
            sb.mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // one input transfer, entered and left at a falling edge
    task automatic send_item(input t_action act, input bit wall);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {7'b0, wall};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    // nothing in flight before registers change
    task automatic wait_idle();
        while (sb.pending_cells.size() != 0 || m_axis_tvalid) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_rule(input bit closing, input int sx, input int sy,
                            input int fx, input int fy, input int rad);
        wait_idle();
        apb_write(REG_CLOSING, 32'(closing));
        apb_write(REG_START_X, 32'(sx));
        apb_write(REG_START_Y, 32'(sy));
        apb_write(REG_FINISH_X, 32'(fx));
        apb_write(REG_FINISH_Y, 32'(fy));
        apb_write(REG_CLEAR_RAD, 32'(rad));
        apb_check(REG_CLEAR_RAD, 32'(rad));
        apb_check(REG_START_X, 32'(sx));
    endtask

    task automatic set_geometry(input int w, input int h);
        wait_idle();
        apb_write(REG_GRID_W, 32'(w));
        apb_write(REG_GRID_H, 32'(h));
        apb_check(REG_GRID_W, 32'(w));
    endtask

    // whole frame with optional early flush, stray cell while draining and a long hold
    task automatic run_frame(input int w, input int h, input int density,
                             input bit early_flush, input bit late_cell, input int hold_at);
        int unsigned n_cells;
        set_geometry(w, h);
        n_cells = sb.eff_width() * sb.eff_height();
        if (early_flush) send_item(ACT_FLUSH, 1'b0);
        for (int i = 0; i < int'(n_cells); i++) begin
            if (i == hold_at) hold_req = 1'b1;
            send_item(ACT_CELL, $urandom_range(99) < density);
        end
        if (late_cell) send_item(ACT_CELL, 1'b1);
        while (sb.draining()) send_item(ACT_FLUSH, 1'b0);
    endtask

    // part of a frame, later cut short by a geometry write
    task automatic run_partial(input int w, input int h, input int n_cells);
        set_geometry(w, h);
        for (int i = 0; i < n_cells; i++) begin
            send_item(ACT_CELL, $urandom_range(99) < 50);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // no idling, with a long receiver hold in the middle of the frame
        set_rule(1'b1, 2, 2, 13, 9, 4);
        run_frame(16, 12, 40, 1'b1, 1'b1, 60);

        // sender idle
        send_idle_pct = 57;
        set_rule(1'b1, 0, 0, 19, 9, 9);
        run_frame(20, 10, 20, 1'b0, 1'b0, -1);
        run_frame(8, 6, 50, 1'b1, 1'b0, -1);

        // receiver stalling, small and clamped grids
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        set_rule(1'b0, 3, 3, 6, 6, 2);
        run_frame(13, 9, 45, 1'b0, 1'b1, -1);
        run_frame(3, 2, 50, 1'b1, 1'b1, -1);
        run_frame(1, 1, 50, 1'b0, 1'b1, -1);
        run_frame(0, 5, 50, 1'b0, 1'b0, -1);
        run_frame(7, 0, 50, 1'b0, 1'b0, -1);

        // both idling, frame restarted by a geometry write
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        set_rule(1'b1, 5, 5, 200, 200, 2);
        run_partial(12, 11, 30);
        run_frame(12, 11, 15, 1'b0, 0, -1);

        wait_idle();
        repeat (10) @(negedge i_clk);

        $display("ran %0d input transfers over full, small and clamped grids, %0d cells checked",
                 items_sent, sb.checked);
        $display("covered early flushes, stray cells while draining, restarts and back-pressure");
        if (sb.mismatches == 0 && sb.pending_cells.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
